/* src/sha0_pkg.sv */
package sha0_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha0_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha0_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } sha0_state_t;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_AW    = $clog2(CMD_DEPTH);

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LAST_SLOT   = 6'd63;
  localparam logic [5:0] LENGTH_SLOT = 6'd56;
  localparam logic [3:0] LEN_BYTES   = 4'd8;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [2:0] LAST_WORD   = 3'd4;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0: w = H0;
      3'd1: w = H1;
      3'd2: w = H2;
      3'd3: w = H3;
      default: w = H4;
    endcase
    return w;
  endfunction

endpackage

/* src/sha0_front.sv */
module sha0_front import sha0_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  sha0_in_t in_item,
  output logic     cmd_valid,
  output sha0_in_t cmd,
  input  logic     cmd_take
);

  sha0_in_t            slots [CMD_DEPTH];
  logic [CMD_AW-1:0]   wr_ptr;
  logic [CMD_AW-1:0]   rd_ptr;
  logic [CMD_AW:0]     count;
  logic                keep;
  logic                do_wr;
  logic                do_rd;

  assign full      = (count == (CMD_AW+1)'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];

  // items carrying neither a byte nor an end are accepted and dropped here
  assign keep  = in_item.has_byte | in_item.end_of_message;
  assign do_wr = push & ~full & keep;
  assign do_rd = cmd_take & cmd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/sha0_core.sv */
module sha0_core import sha0_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  sha0_in_t  cmd,
  output logic      cmd_take,
  output logic      empty,
  input  logic      pop,
  output sha0_out_t out_item
);

  sha0_state_t state;
  sha0_state_t state_next;

  logic [511:0] blk;
  logic [31:0]  chain [5];
  logic [31:0]  a, b, c, d, e;
  logic [63:0]  bit_length;
  logic [63:0]  len_sr;
  logic [5:0]   pos;
  logic [6:0]   rnd;
  logic [3:0]   len_cnt;
  logic [2:0]   idx;
  logic         pad_on;
  logic         pad_first;

  logic         put_en;
  logic [7:0]   put_val;
  logic         put_len;
  logic         emit_done;
  logic [63:0]  len_next;

  logic [31:0]  w0, w2, w8, w13, w_new;
  logic [31:0]  f, k, tmp;

  // schedule window: word 0 is the word for the current round
  assign w0    = blk[511:480];
  assign w2    = blk[447:416];
  assign w8    = blk[255:224];
  assign w13   = blk[95:64];
  assign w_new = w13 ^ w8 ^ w2 ^ w0;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + w0;

  assign len_next  = bit_length + (cmd.has_byte ? 64'd8 : 64'd0);
  assign emit_done = pop & (idx == LAST_WORD);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.has_byte && pos == LAST_SLOT) begin
            state_next = ST_ROUND;
          end else if (cmd.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!pad_on) begin
          state_next = ST_IDLE;
        end else if (len_cnt == LEN_BYTES) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos == LAST_SLOT) begin
          state_next = ST_ROUND;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_take = 1'b0;
    put_en   = 1'b0;
    put_val  = cmd.data_byte;
    put_len  = 1'b0;
    empty    = 1'b1;
    case (state)
      ST_IDLE: begin
        cmd_take = cmd_valid;
        put_en   = cmd_valid & cmd.has_byte;
      end
      ST_PAD: begin
        put_en = 1'b1;
        if (pad_first) begin
          put_val = PAD_BYTE;
        end else if (len_cnt == '0 && pos != LENGTH_SLOT) begin
          put_val = 8'h00;
        end else begin
          put_val = len_sr[63:56];
          put_len = 1'b1;
        end
      end
      ST_EMIT: begin
        empty = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_item.digest_word = chain[idx];
  assign out_item.word_index  = idx;
  assign out_item.last_word   = (idx == LAST_WORD);

  // block buffer doubles as the schedule shift line
  always_ff @(posedge clk) begin
    if (put_en) begin
      blk <= {blk[503:0], put_val};
    end else if (state == ST_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0;
      b <= '0;
      c <= '0;
      d <= '0;
      e <= '0;
    end else if (put_en && pos == LAST_SLOT) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == ST_ROUND) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (put_len) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end else if (cmd_take && cmd.end_of_message) begin
      len_sr <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bit_length <= '0;
      pos        <= '0;
      rnd        <= '0;
      len_cnt    <= '0;
      idx        <= '0;
      pad_on     <= 1'b0;
      pad_first  <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= init_word(3'(i));
      end
    end else begin
      state <= state_next;

      if (cmd_take) begin
        bit_length <= cmd.end_of_message ? 64'd0 : len_next;
        if (cmd.end_of_message) begin
          pad_on    <= 1'b1;
          pad_first <= 1'b1;
          len_cnt   <= '0;
        end
      end

      if (put_en) begin
        pos <= pos + 1'b1;
      end

      if (state == ST_PAD) begin
        pad_first <= 1'b0;
      end
      if (put_len) begin
        len_cnt <= len_cnt + 1'b1;
      end

      if (state == ST_ROUND) begin
        rnd <= (rnd == LAST_ROUND) ? 7'd0 : rnd + 1'b1;
      end

      if (state == ST_ADD) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
        if (pad_on && len_cnt == LEN_BYTES) begin
          pad_on <= 1'b0;
        end
      end

      if (state == ST_EMIT && pop) begin
        if (idx == LAST_WORD) begin
          idx <= '0;
          for (int i = 0; i < 5; i++) begin
            chain[i] <= init_word(3'(i));
          end
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

/* src/sha0_message_digest_top.sv */
// channel | handshake   | payload
// --------+-------------+------------------------------------------------
// input   | push / full | in_item: data_byte, has_byte, end_of_message
// result  | empty / pop | out_item: digest_word, word_index, last_word
//
// while idle, the core shifts each message byte from the 4-entry queue into its block
// each full 64-byte block then runs 80 rounds followed by the chain add
// the end of a message pads one byte a cycle (up to 72) plus one or two blocks
// digest words leave one per pop from the chain registers, five per message
// rst is synchronous and restores the initial chain value with the queue empty
// the input queue keeps taking items, until it is full, while digest words wait to be popped
module sha0_message_digest_top import sha0_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  sha0_in_t  in_item,
  output logic      empty,
  input  logic      pop,
  output sha0_out_t out_item
);

  logic     cmd_valid;
  logic     cmd_take;
  sha0_in_t cmd;

  sha0_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sha0_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
